>>> rtl/tmh_pkg.sv
// ----------------------------------------------------------------------------
// tmh_pkg
// Shared types and constants for the turbine mode hysteresis machine.
// ----------------------------------------------------------------------------
package tmh_pkg;

  localparam int CountWidth = 24;
  localparam int RpmWidth   = 16;
  localparam int TicksWidth = 24;
  localparam int CfgIdxWidth  = 3;
  localparam int CfgDataWidth = 24;
  localparam int CmpWidth   = 32;

  localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};

  localparam logic [CfgIdxWidth-1:0] RegStallExit   = 3'd0;
  localparam logic [CfgIdxWidth-1:0] RegStallEntry  = 3'd1;
  localparam logic [CfgIdxWidth-1:0] RegTorqueToPitch = 3'd2;
  localparam logic [CfgIdxWidth-1:0] RegPitchToTorque = 3'd3;
  localparam logic [CfgIdxWidth-1:0] RegPitchToEmerg  = 3'd4;
  localparam logic [CfgIdxWidth-1:0] RegPersistTicks  = 3'd5;

  localparam logic [RpmWidth-1:0]   RstStallExit     = 16'd200;
  localparam logic [RpmWidth-1:0]   RstStallEntry    = 16'd120;
  localparam logic [RpmWidth-1:0]   RstTorqueToPitch = 16'd1900;
  localparam logic [RpmWidth-1:0]   RstPitchToTorque = 16'd1700;
  localparam logic [RpmWidth-1:0]   RstPitchToEmerg  = 16'd2200;
  localparam logic [TicksWidth-1:0] RstPersistTicks  = 24'd3000000;

  // input kind carried in tuser
  localparam logic KindSample = 1'b0;
  localparam logic KindTick   = 1'b1;

  // encoded turbine mode codes
  localparam logic [1:0] CodeStall  = 2'd0;
  localparam logic [1:0] CodeTorque = 2'd1;
  localparam logic [1:0] CodePitch  = 2'd2;
  localparam logic [1:0] CodeEmerg  = 2'd3;

  typedef enum logic [3:0] {
    ModeStall  = 4'b0001,
    ModeTorque = 4'b0010,
    ModePitch  = 4'b0100,
    ModeEmerg  = 4'b1000
  } mode_t;

  typedef struct packed {
    logic [RpmWidth-1:0]   stall_exit_rpm;
    logic [RpmWidth-1:0]   stall_entry_rpm;
    logic [RpmWidth-1:0]   torque_to_pitch_rpm;
    logic [RpmWidth-1:0]   pitch_to_torque_rpm;
    logic [RpmWidth-1:0]   pitch_to_emergency_rpm;
    logic [TicksWidth-1:0] persist_ticks;
  } cfg_t;

  typedef struct packed {
    logic       change_pending;
    logic       mode_changed;
    logic [1:0] turbine_mode;
  } result_t;

  function automatic logic [1:0] mode_code(mode_t m);
    logic [1:0] c;
    c = CodeStall;
    unique case (m)
      ModeStall:  c = CodeStall;
      ModeTorque: c = CodeTorque;
      ModePitch:  c = CodePitch;
      ModeEmerg:  c = CodeEmerg;
      default:    c = CodeStall;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/tmh_cfg_regs.sv
// ----------------------------------------------------------------------------
// tmh_cfg_regs
// Threshold and persistence registers with a plain indexed write port.
// ----------------------------------------------------------------------------
module tmh_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [tmh_pkg::CfgIdxWidth-1:0]     cfg_addr,
  input  logic [tmh_pkg::CfgDataWidth-1:0]    cfg_wdata,
  output tmh_pkg::cfg_t                       cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stall_exit_rpm         <= tmh_pkg::RstStallExit;
      cfg.stall_entry_rpm        <= tmh_pkg::RstStallEntry;
      cfg.torque_to_pitch_rpm    <= tmh_pkg::RstTorqueToPitch;
      cfg.pitch_to_torque_rpm    <= tmh_pkg::RstPitchToTorque;
      cfg.pitch_to_emergency_rpm <= tmh_pkg::RstPitchToEmerg;
      cfg.persist_ticks          <= tmh_pkg::RstPersistTicks;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        tmh_pkg::RegStallExit:
          cfg.stall_exit_rpm <= cfg_wdata[tmh_pkg::RpmWidth-1:0];
        tmh_pkg::RegStallEntry:
          cfg.stall_entry_rpm <= cfg_wdata[tmh_pkg::RpmWidth-1:0];
        tmh_pkg::RegTorqueToPitch:
          cfg.torque_to_pitch_rpm <= cfg_wdata[tmh_pkg::RpmWidth-1:0];
        tmh_pkg::RegPitchToTorque:
          cfg.pitch_to_torque_rpm <= cfg_wdata[tmh_pkg::RpmWidth-1:0];
        tmh_pkg::RegPitchToEmerg:
          cfg.pitch_to_emergency_rpm <= cfg_wdata[tmh_pkg::RpmWidth-1:0];
        tmh_pkg::RegPersistTicks:
          cfg.persist_ticks <= cfg_wdata[tmh_pkg::TicksWidth-1:0];
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/tmh_core.sv
// ----------------------------------------------------------------------------
// tmh_core
// Mode state, persistence delay and next-state logic for one beat.
// ----------------------------------------------------------------------------
module tmh_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          kind,
  input  logic [tmh_pkg::RpmWidth-1:0]  rpm,
  input  tmh_pkg::cfg_t                 cfg,
  output tmh_pkg::result_t              res
);

  tmh_pkg::mode_t                  cur_mode, cur_mode_next, wanted;
  logic                            armed, armed_next;
  logic                            elapsed, elapsed_next;
  logic [tmh_pkg::CountWidth-1:0]  count, count_next, count_inc;
  logic                            changed;

  always_comb begin
    wanted = cur_mode;
    unique case (cur_mode)
      tmh_pkg::ModeStall: begin
        wanted = (rpm >= cfg.stall_exit_rpm) ? tmh_pkg::ModeTorque : tmh_pkg::ModeStall;
      end
      tmh_pkg::ModeTorque: begin
        priority if (rpm <= cfg.stall_entry_rpm) wanted = tmh_pkg::ModeStall;
        else if (rpm >= cfg.torque_to_pitch_rpm) wanted = tmh_pkg::ModePitch;
        else wanted = tmh_pkg::ModeTorque;
      end
      tmh_pkg::ModePitch: begin
        priority if (rpm >= cfg.pitch_to_emergency_rpm) wanted = tmh_pkg::ModeEmerg;
        else if (rpm <= cfg.pitch_to_torque_rpm) wanted = tmh_pkg::ModeTorque;
        else wanted = tmh_pkg::ModePitch;
      end
      tmh_pkg::ModeEmerg: wanted = tmh_pkg::ModeEmerg;
      default: wanted = tmh_pkg::ModeEmerg;
    endcase
  end

  assign count_inc = (count == tmh_pkg::CountMax) ? count
                   : count + tmh_pkg::CountWidth'(1);

  always_comb begin
    cur_mode_next = cur_mode;
    armed_next    = armed;
    elapsed_next  = elapsed;
    count_next    = count;
    changed       = 1'b0;
    if (kind == tmh_pkg::KindTick) begin
      if (armed) begin
        count_next = count_inc;
        if (tmh_pkg::CmpWidth'(count_inc) >= tmh_pkg::CmpWidth'(cfg.persist_ticks)) begin
          elapsed_next = 1'b1;
          armed_next   = 1'b0;
        end
      end
    end else begin
      priority if (wanted == cur_mode) begin
        armed_next   = 1'b0;
        elapsed_next = 1'b0;
        count_next   = '0;
      end else if (!elapsed) begin
        if (!armed) begin
          armed_next = 1'b1;
          count_next = '0;
        end
      end else begin
        armed_next    = 1'b0;
        elapsed_next  = 1'b0;
        count_next    = '0;
        cur_mode_next = wanted;
        changed       = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_mode <= tmh_pkg::ModeStall;
      armed    <= 1'b0;
      elapsed  <= 1'b0;
      count    <= '0;
    end else if (en) begin
      cur_mode <= cur_mode_next;
      armed    <= armed_next;
      elapsed  <= elapsed_next;
      count    <= count_next;
    end
  end

  assign res.turbine_mode   = tmh_pkg::mode_code(cur_mode_next);
  assign res.mode_changed   = changed;
  assign res.change_pending = armed_next;

endmodule

>>> rtl/turbine_mode_hysteresis_fsm.sv
// ----------------------------------------------------------------------------
// turbine_mode_hysteresis_fsm
// Four-mode turbine machine with hysteresis thresholds and persistence delay.
// ----------------------------------------------------------------------------
// Input beat to result beat passes two registers: input reg, result reg.
// Throughput: one beat per cycle unless m_tready stalls the output; the mode update is the loop.
// Reset (rst, synchronous): mode stall, delay cleared, thresholds to defaults,
// both pipeline registers empty.
module turbine_mode_hysteresis_fsm (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [tmh_pkg::CfgIdxWidth-1:0]     cfg_addr,
  input  logic [tmh_pkg::CfgDataWidth-1:0]    cfg_wdata,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [15:0]                         s_tdata,   // [15:0] rotor_rpm
  input  logic                                s_tuser,   // [0] kind (1 = tick)
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [7:0]                          m_tdata    // [1:0] turbine_mode,
                                                         // [2] mode_changed,
                                                         // [3] change_pending
);

  tmh_pkg::cfg_t                   cfg;
  tmh_pkg::result_t                res;
  tmh_pkg::result_t                out_res;
  logic                            in_valid;
  logic                            in_kind;
  logic [tmh_pkg::RpmWidth-1:0]    in_rpm;
  logic                            advance;

  tmh_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_kind <= s_tuser;
      in_rpm  <= s_tdata;
    end
  end

  tmh_core u_core (
    .clk  (clk),
    .rst  (rst),
    .en   (advance),
    .kind (in_kind),
    .rpm  (in_rpm),
    .cfg  (cfg),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign m_tdata = {4'b0000, out_res};

  a_tick_no_change: assert property (@(posedge clk) disable iff (rst)
    (advance && in_kind == tmh_pkg::KindTick) |-> !res.mode_changed)
    else $error("tick beat reported a mode change");

  a_change_clears_delay: assert property (@(posedge clk) disable iff (rst)
    (advance && res.mode_changed) |-> !res.change_pending)
    else $error("mode change left the delay armed");

  a_emerg_sticks: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_res.turbine_mode == tmh_pkg::CodeEmerg && advance)
      |-> (res.turbine_mode == tmh_pkg::CodeEmerg))
    else $error("left emergency without reset");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !in_valid |-> s_tready)
    else $error("empty input stage not ready");

endmodule
